### rtl/mpvs_pkg.sv
// Shared types, constants and format byte codes for the MessagePack value skipper.
`timescale 1ns / 1ps

package mpvs_pkg;

	// Stack of values-left counters
	localparam int STACK_DEPTH = 32;
	localparam int LVL_W       = $clog2(STACK_DEPTH);
	localparam int ENTRY_W     = 33;
	localparam int NEST_W      = 8;
	localparam int BYTES_W     = 32;

	// Format byte codes and masks
	localparam logic [7:0] FB_POSFIX_MAX = 8'h7f;
	localparam logic [7:0] FB_NEGFIX_MIN = 8'he0;
	localparam logic [7:0] FB_HI3_MASK   = 8'he0;
	localparam logic [7:0] FB_HI4_MASK   = 8'hf0;
	localparam logic [7:0] FB_FIXSTR     = 8'ha0;
	localparam logic [7:0] FB_FIXMAP     = 8'h80;
	localparam logic [7:0] FB_FIXARRAY   = 8'h90;
	localparam logic [7:0] FB_NIL        = 8'hc0;
	localparam logic [7:0] FB_FALSE      = 8'hc2;
	localparam logic [7:0] FB_TRUE       = 8'hc3;
	localparam logic [7:0] FB_BIN8       = 8'hc4;
	localparam logic [7:0] FB_BIN16      = 8'hc5;
	localparam logic [7:0] FB_BIN32      = 8'hc6;
	localparam logic [7:0] FB_FLOAT32    = 8'hca;
	localparam logic [7:0] FB_FLOAT64    = 8'hcb;
	localparam logic [7:0] FB_UINT8      = 8'hcc;
	localparam logic [7:0] FB_UINT16     = 8'hcd;
	localparam logic [7:0] FB_UINT32     = 8'hce;
	localparam logic [7:0] FB_UINT64     = 8'hcf;
	localparam logic [7:0] FB_INT8       = 8'hd0;
	localparam logic [7:0] FB_INT16      = 8'hd1;
	localparam logic [7:0] FB_INT32      = 8'hd2;
	localparam logic [7:0] FB_INT64      = 8'hd3;
	localparam logic [7:0] FB_STR8       = 8'hd9;
	localparam logic [7:0] FB_STR16      = 8'hda;
	localparam logic [7:0] FB_STR32      = 8'hdb;
	localparam logic [7:0] FB_ARRAY16    = 8'hdc;
	localparam logic [7:0] FB_ARRAY32    = 8'hdd;
	localparam logic [7:0] FB_MAP16      = 8'hde;
	localparam logic [7:0] FB_MAP32      = 8'hdf;
	localparam logic [7:0] FB_LEN5_MASK  = 8'h1f;
	localparam logic [7:0] FB_CNT4_MASK  = 8'h0f;

	typedef enum logic [1:0] {
		STAT_BUSY = 2'd0,
		STAT_DONE = 2'd1,
		STAT_ERR  = 2'd2
	} status_t;

	typedef enum logic [1:0] {
		PH_FORMAT  = 2'd0,
		PH_HEADER  = 2'd1,
		PH_PAYLOAD = 2'd2
	} phase_t;

	typedef enum logic [1:0] {
		HK_NONE  = 2'd0,
		HK_LEN   = 2'd1,
		HK_ARRAY = 2'd2,
		HK_MAP   = 2'd3
	} hkind_t;

	typedef enum logic [2:0] {
		ACT_VALUE   = 3'd0,
		ACT_PAYLOAD = 3'd1,
		ACT_OPEN    = 3'd2,
		ACT_HEADER  = 3'd3,
		ACT_ERR     = 3'd4
	} act_kind_t;

	// What a byte asks for once its phase is decoded
	typedef enum logic [2:0] {
		REQ_BUSY    = 3'd0,
		REQ_ERR     = 3'd1,
		REQ_VEND    = 3'd2,
		REQ_PAYLOAD = 3'd3,
		REQ_OPEN    = 3'd4
	} req_t;

	typedef enum logic [1:0] {
		SQ_IDLE = 2'd0,
		SQ_PROC = 2'd1,
		SQ_DECR = 2'd2,
		SQ_HOLD = 2'd3
	} seq_state_t;

	// Decoded format byte
	typedef struct packed {
		act_kind_t            kind;
		logic [BYTES_W-1:0]   len;
		logic [ENTRY_W-1:0]   cnt;
		hkind_t               hkind;
		logic [2:0]           hlen;
	} fmt_act_t;

endpackage

### rtl/mpvs_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module mpvs_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
		rdata <= mem_q[raddr];
	end

endmodule

### rtl/mpvs_dec_unit.sv
// Shared 33-bit decrement and zero test used for counters.
`timescale 1ns / 1ps

module mpvs_dec_unit
	import mpvs_pkg::*;
(
	input  logic [ENTRY_W-1:0] op,
	output logic [ENTRY_W-1:0] res,
	output logic               res_zero
);

	assign res      = op - ENTRY_W'(1);
	assign res_zero = (res == '0);

endmodule

### rtl/mpvs_fmt_dec.sv
// Format byte decoder: maps a MessagePack format byte to an action.
`timescale 1ns / 1ps

module mpvs_fmt_dec
	import mpvs_pkg::*;
(
	input  logic [7:0] data,
	output fmt_act_t   act
);

	always_comb begin
		act.kind  = ACT_ERR;
		act.len   = '0;
		act.cnt   = '0;
		act.hkind = HK_NONE;
		act.hlen  = 3'd0;
		priority if (data <= FB_POSFIX_MAX || data >= FB_NEGFIX_MIN) begin
			act.kind = ACT_VALUE;
		end else if ((data & FB_HI3_MASK) == FB_FIXSTR) begin
			act.kind = ACT_PAYLOAD;
			act.len  = BYTES_W'(data & FB_LEN5_MASK);
		end else if ((data & FB_HI4_MASK) == FB_FIXMAP) begin
			act.kind = ACT_OPEN;
			act.cnt  = {ENTRY_W'(data & FB_CNT4_MASK)} << 1;
		end else if ((data & FB_HI4_MASK) == FB_FIXARRAY) begin
			act.kind = ACT_OPEN;
			act.cnt  = ENTRY_W'(data & FB_CNT4_MASK);
		end else begin
			unique case (data)
				FB_NIL, FB_FALSE, FB_TRUE: act.kind = ACT_VALUE;
				FB_BIN8, FB_STR8: begin
					act.kind = ACT_HEADER; act.hkind = HK_LEN; act.hlen = 3'd1;
				end
				FB_BIN16, FB_STR16: begin
					act.kind = ACT_HEADER; act.hkind = HK_LEN; act.hlen = 3'd2;
				end
				FB_BIN32, FB_STR32: begin
					act.kind = ACT_HEADER; act.hkind = HK_LEN; act.hlen = 3'd4;
				end
				FB_UINT8, FB_INT8: begin
					act.kind = ACT_PAYLOAD; act.len = BYTES_W'(1);
				end
				FB_UINT16, FB_INT16: begin
					act.kind = ACT_PAYLOAD; act.len = BYTES_W'(2);
				end
				FB_FLOAT32, FB_UINT32, FB_INT32: begin
					act.kind = ACT_PAYLOAD; act.len = BYTES_W'(4);
				end
				FB_FLOAT64, FB_UINT64, FB_INT64: begin
					act.kind = ACT_PAYLOAD; act.len = BYTES_W'(8);
				end
				FB_ARRAY16: begin
					act.kind = ACT_HEADER; act.hkind = HK_ARRAY; act.hlen = 3'd2;
				end
				FB_ARRAY32: begin
					act.kind = ACT_HEADER; act.hkind = HK_ARRAY; act.hlen = 3'd4;
				end
				FB_MAP16: begin
					act.kind = ACT_HEADER; act.hkind = HK_MAP; act.hlen = 3'd2;
				end
				FB_MAP32: begin
					act.kind = ACT_HEADER; act.hkind = HK_MAP; act.hlen = 3'd4;
				end
				default: act.kind = ACT_ERR;
			endcase
		end
	end

endmodule

### rtl/msgpack_value_skipper_core.sv
// Top level of the MessagePack value skipper: sequencer, counter stack and result register.
`timescale 1ns / 1ps

//  channel | signals                               | dir | item
//  --------+---------------------------------------+-----+-------------------------------
//  in      | in_valid, in_ready, data_byte,        | in  | one byte of the message
//          | final_byte                            |     |
//  out     | out_valid, out_ready, status,         | out | one result per byte
//          | bytes_used, nest_level                |     |
//
//  A byte that does not finish a value is accepted, then decoded.
//  A byte that finishes a value then steps through the stack counters checked by the
//  shared decrement unit, one counter per step (one per container closed, plus one).
//  A result waiting in the output register stalls only the final step of the next byte.
//  Reset clears the sequencer and restarts at format-byte phase with one value pending;
//  the stack RAM needs no clearing since every entry is written before it is read.

module msgpack_value_skipper_core
	import mpvs_pkg::*;
(
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  logic [7:0]         data_byte,
	input  logic               final_byte,
	output logic               out_valid,
	input  logic               out_ready,
	output logic [1:0]         status,
	output logic [BYTES_W-1:0] bytes_used,
	output logic [NEST_W-1:0]  nest_level
);

	// Sequencer and decode state
	seq_state_t         state_q, state_nx;
	phase_t             phase_q, phase_nx;
	hkind_t             hkind_q, hkind_nx;
	logic [2:0]         hleft_q, hleft_nx;
	logic [31:0]        haccum_q, haccum_nx;
	logic [BYTES_W-1:0] pleft_q, pleft_nx;
	logic [LVL_W-1:0]   level_q, level_nx;
	logic [ENTRY_W-1:0] tos_q, tos_nx;      // values_left[level], kept out of the RAM
	logic [BYTES_W-1:0] btotal_q, btotal_nx;
	logic               pop_q, pop_nx;      // RAM read data feeds the unit this cycle
	status_t            st_q;               // status parked while output is full

	// Latched input item
	logic [7:0]         byte_q;
	logic               fin_q;
	logic [LVL_W-1:0]   held_q;

	// Output register
	logic               out_valid_q;
	status_t            out_st_q;
	logic [BYTES_W-1:0] out_bytes_q;
	logic [NEST_W-1:0]  out_nest_q;

	logic               accept;
	logic               out_free;
	logic               emit;
	logic               restart;
	logic               res_valid;
	status_t            res_st;
	status_t            fin_st;
	logic               go_decr;

	// Stack RAM
	logic               ram_we;
	logic [LVL_W-1:0]   ram_raddr;
	logic [ENTRY_W-1:0] ram_rdata;

	// Shared decrement unit
	logic [ENTRY_W-1:0] unit_op;
	logic [ENTRY_W-1:0] unit_res;
	logic               unit_zero;

	fmt_act_t           fmt_act;

	mpvs_fmt_dec u_fmt_dec (
		.data (byte_q),
		.act  (fmt_act)
	);

	mpvs_dec_unit u_dec_unit (
		.op       (unit_op),
		.res      (unit_res),
		.res_zero (unit_zero)
	);

	mpvs_ram #(
		.WIDTH (ENTRY_W),
		.DEPTH (STACK_DEPTH)
	) u_stack_ram (
		.clk   (clk),
		.we    (ram_we),
		.waddr (level_q),
		.wdata (tos_q),
		.raddr (ram_raddr),
		.rdata (ram_rdata)
	);

	assign accept   = in_valid && in_ready;
	assign out_free = !out_valid_q || out_ready;
	assign emit     = res_valid && out_free;
	// a byte that leaves the value open on the last byte of the buffer is an error
	assign fin_st   = (res_st == STAT_BUSY && fin_q) ? STAT_ERR : res_st;
	// Restart after a complete value or an error
	assign restart  = emit && fin_st != STAT_BUSY;

	// The unit counts down the top counter while unwinding, else the payload count
	assign unit_op  = (state_q == SQ_DECR) ? (pop_q ? ram_rdata : tos_q)
	                                        : {1'b0, pleft_q};

	// Handshake outputs
	always_comb begin
		in_ready   = (state_q == SQ_IDLE);
		out_valid  = out_valid_q;
		status     = out_st_q;
		bytes_used = out_bytes_q;
		nest_level = out_nest_q;
	end

	// Next state
	always_comb begin
		state_nx = state_q;
		unique case (state_q)
			SQ_IDLE: if (accept) state_nx = SQ_PROC;
			SQ_PROC: begin
				if (go_decr)        state_nx = SQ_DECR;
				else if (res_valid) state_nx = emit ? SQ_IDLE : SQ_HOLD;
			end
			SQ_DECR: if (res_valid) state_nx = emit ? SQ_IDLE : SQ_HOLD;
			SQ_HOLD: if (out_free)  state_nx = SQ_IDLE;
			default: state_nx = SQ_IDLE;
		endcase
	end

	// Datapath and stack control
	always_comb begin
		req_t               req;
		logic [BYTES_W-1:0] req_len;
		logic [ENTRY_W-1:0] req_cnt;
		logic [31:0]        accum_n;
		logic [2:0]         hleft_n;

		phase_nx  = phase_q;
		hkind_nx  = hkind_q;
		hleft_nx  = hleft_q;
		haccum_nx = haccum_q;
		pleft_nx  = pleft_q;
		level_nx  = level_q;
		tos_nx    = tos_q;
		btotal_nx = btotal_q;
		pop_nx    = 1'b0;
		res_valid = 1'b0;
		res_st    = STAT_BUSY;
		go_decr   = 1'b0;
		ram_we    = 1'b0;
		ram_raddr = level_q - LVL_W'(1);
		req       = REQ_BUSY;
		req_len   = '0;
		req_cnt   = '0;
		accum_n   = {haccum_q[23:0], byte_q};
		hleft_n   = hleft_q - 3'd1;

		unique case (state_q)
			SQ_IDLE: begin
				if (accept && btotal_q != '1) begin
					btotal_nx = btotal_q + BYTES_W'(1);
				end
			end

			SQ_PROC: begin
				unique case (phase_q)
					PH_FORMAT: begin
						unique case (fmt_act.kind)
							ACT_VALUE:   req = REQ_VEND;
							ACT_PAYLOAD: begin
								req     = REQ_PAYLOAD;
								req_len = fmt_act.len;
							end
							ACT_OPEN: begin
								req     = REQ_OPEN;
								req_cnt = fmt_act.cnt;
							end
							ACT_HEADER: begin
								req       = REQ_BUSY;
								phase_nx  = PH_HEADER;
								hkind_nx  = fmt_act.hkind;
								hleft_nx  = fmt_act.hlen;
								haccum_nx = '0;
							end
							default:     req = REQ_ERR;
						endcase
					end
					PH_HEADER: begin
						haccum_nx = accum_n;
						hleft_nx  = hleft_n;
						if (hleft_n != 3'd0) begin
							req = REQ_BUSY;
						end else begin
							phase_nx = PH_FORMAT;
							unique case (hkind_q)
								HK_LEN: begin
									req     = REQ_PAYLOAD;
									req_len = accum_n;
								end
								HK_MAP: begin
									req     = REQ_OPEN;
									req_cnt = {accum_n, 1'b0};
								end
								default: begin
									req     = REQ_OPEN;
									req_cnt = {1'b0, accum_n};
								end
							endcase
						end
					end
					PH_PAYLOAD: begin
						pleft_nx = unit_res[BYTES_W-1:0];
						if (unit_zero) begin
							phase_nx = PH_FORMAT;
							req      = REQ_VEND;
						end else begin
							req = REQ_BUSY;
						end
					end
					default: req = REQ_ERR;
				endcase

				// Resolve what the byte asked for
				unique case (req)
					REQ_BUSY: begin
						res_valid = 1'b1;
						res_st    = STAT_BUSY;
					end
					REQ_ERR: begin
						res_valid = 1'b1;
						res_st    = STAT_ERR;
					end
					REQ_VEND: go_decr = 1'b1;
					REQ_PAYLOAD: begin
						if (req_len == '0) begin
							go_decr = 1'b1;
						end else begin
							phase_nx  = PH_PAYLOAD;
							pleft_nx  = req_len;
							res_valid = 1'b1;
							res_st    = STAT_BUSY;
						end
					end
					REQ_OPEN: begin
						if (req_cnt == '0) begin
							go_decr = 1'b1;
						end else if (level_q == LVL_W'(STACK_DEPTH - 1)) begin
							// no room for another counter
							res_valid = 1'b1;
							res_st    = STAT_ERR;
						end else begin
							ram_we    = 1'b1;
							level_nx  = level_q + LVL_W'(1);
							tos_nx    = req_cnt;
							phase_nx  = PH_FORMAT;
							res_valid = 1'b1;
							res_st    = STAT_BUSY;
						end
					end
					default: begin
						res_valid = 1'b1;
						res_st    = STAT_ERR;
					end
				endcase
			end

			SQ_DECR: begin
				// one counter per cycle: count off a value, close the container if empty
				tos_nx = unit_res;
				if (!unit_zero) begin
					res_valid = 1'b1;
					res_st    = STAT_BUSY;
				end else if (level_q == '0) begin
					res_valid = 1'b1;
					res_st    = STAT_DONE;
				end else begin
					level_nx = level_q - LVL_W'(1);
					pop_nx   = 1'b1;
				end
			end

			SQ_HOLD: begin
				res_valid = 1'b1;
				res_st    = st_q;
			end

			default: ;
		endcase
	end

	// Control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= SQ_IDLE;
			phase_q     <= PH_FORMAT;
			hkind_q     <= HK_NONE;
			hleft_q     <= 3'd0;
			haccum_q    <= '0;
			pleft_q     <= '0;
			level_q     <= '0;
			tos_q       <= ENTRY_W'(1);
			btotal_q    <= '0;
			pop_q       <= 1'b0;
			st_q        <= STAT_BUSY;
			out_valid_q <= 1'b0;
		end else begin
			state_q  <= state_nx;
			pop_q    <= pop_nx;
			if (restart) begin
				phase_q  <= PH_FORMAT;
				hkind_q  <= HK_NONE;
				hleft_q  <= 3'd0;
				haccum_q <= '0;
				pleft_q  <= '0;
				level_q  <= '0;
				tos_q    <= ENTRY_W'(1);
				btotal_q <= '0;
			end else begin
				phase_q  <= phase_nx;
				hkind_q  <= hkind_nx;
				hleft_q  <= hleft_nx;
				haccum_q <= haccum_nx;
				pleft_q  <= pleft_nx;
				level_q  <= level_nx;
				tos_q    <= tos_nx;
				btotal_q <= btotal_nx;
			end
			if (res_valid) begin
				st_q <= res_st;
			end
			if (emit) begin
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// Payload registers
	always_ff @(posedge clk) begin
		if (accept) begin
			byte_q <= data_byte;
			fin_q  <= final_byte;
			held_q <= level_q;
		end
		if (emit) begin
			out_st_q    <= fin_st;
			out_bytes_q <= btotal_q;
			// an error reports the depth held when the byte arrived; a complete value sits at zero
			out_nest_q  <= (fin_st == STAT_ERR) ? NEST_W'(held_q) : NEST_W'(level_nx);
		end
	end

endmodule

### sim/tb_msgpack_value_skipper_core.sv
// Testbench for msgpack_value_skipper_core: directed and random MessagePack byte streams checked byte by byte.
`timescale 1ns / 1ps

module tb_msgpack_value_skipper_core;
	import mpvs_pkg::*;

	// Format bytes the block must reject (reserved code and the ext family)
	localparam logic [7:0] FB_RESERVED  = 8'hc1;
	localparam logic [7:0] FB_EXT8      = 8'hc7;
	localparam logic [7:0] FB_EXT32     = 8'hc9;
	localparam logic [7:0] FB_FIXEXT1   = 8'hd4;
	localparam logic [7:0] FB_FIXEXT16  = 8'hd8;

	localparam int TAIL_CYCLES = 40;

	typedef struct packed {
		status_t             st;
		logic [BYTES_W-1:0]  used;
		logic [NEST_W-1:0]   nest;
	} byte_verdict_t;

	// Tracks where the current top-level value ends and keeps the verdict due for each byte
	class msgpack_tracker;
		phase_t               ph;
		hkind_t               hk;
		logic [2:0]           hleft;
		logic [31:0]          hacc;
		logic [31:0]          pleft;
		int unsigned          lvl;
		logic [ENTRY_W-1:0]   stack [STACK_DEPTH];
		logic [BYTES_W-1:0]   total;
		byte_verdict_t        verdicts [$];
		int                   errors;

		function new();
			for (int i = 0; i < STACK_DEPTH; i++)
				stack[i] = '0;
			errors = 0;
			restart();
		endfunction

		function void restart();
			ph = PH_FORMAT;
			hk = HK_NONE;
			hleft = '0;
			hacc = '0;
			pleft = '0;
			lvl = 0;
			stack[0] = ENTRY_W'(1);
			total = '0;
		endfunction

		// Count one finished value off and unwind every container it closes
		function status_t close_value();
			status_t st;
			logic settled;
			st = STAT_BUSY;
			settled = 1'b0;
			while (!settled) begin
				if (lvl >= STACK_DEPTH) begin
					st = STAT_ERR;
					settled = 1'b1;
				end else begin
					stack[lvl] = stack[lvl] - 1'b1;
					if (stack[lvl] != 0) begin
						st = STAT_BUSY;
						settled = 1'b1;
					end else if (lvl == 0) begin
						st = STAT_DONE;
						settled = 1'b1;
					end else begin
						lvl--;
					end
				end
			end
			return st;
		endfunction

		function status_t open_ctr(logic [ENTRY_W-1:0] cnt);
			if (cnt == 0)
				return close_value();
			if (lvl + 1 >= STACK_DEPTH)
				return STAT_ERR;
			lvl++;
			stack[lvl] = cnt;
			ph = PH_FORMAT;
			return STAT_BUSY;
		endfunction

		function status_t begin_header(hkind_t kind, logic [2:0] nbytes);
			ph = PH_HEADER;
			hk = kind;
			hleft = nbytes;
			hacc = '0;
			return STAT_BUSY;
		endfunction

		function status_t begin_payload(logic [31:0] nbytes);
			if (nbytes == 0)
				return close_value();
			ph = PH_PAYLOAD;
			pleft = nbytes;
			return STAT_BUSY;
		endfunction

		function status_t decode_format(logic [7:0] b);
			status_t st;
			if (b <= FB_POSFIX_MAX || b >= FB_NEGFIX_MIN)
				st = close_value();
			else if ((b & FB_HI3_MASK) == FB_FIXSTR)
				st = begin_payload(32'(b & FB_LEN5_MASK));
			else if ((b & FB_HI4_MASK) == FB_FIXMAP)
				st = open_ctr(ENTRY_W'(b & FB_CNT4_MASK) << 1);
			else if ((b & FB_HI4_MASK) == FB_FIXARRAY)
				st = open_ctr(ENTRY_W'(b & FB_CNT4_MASK));
			else begin
				case (b)
				FB_NIL, FB_FALSE, FB_TRUE: st = close_value();
				FB_BIN8, FB_STR8:          st = begin_header(HK_LEN, 3'd1);
				FB_BIN16, FB_STR16:        st = begin_header(HK_LEN, 3'd2);
				FB_BIN32, FB_STR32:        st = begin_header(HK_LEN, 3'd4);
				FB_UINT8, FB_INT8:         st = begin_payload(32'd1);
				FB_UINT16, FB_INT16:       st = begin_payload(32'd2);
				FB_FLOAT32, FB_UINT32, FB_INT32: st = begin_payload(32'd4);
				FB_FLOAT64, FB_UINT64, FB_INT64: st = begin_payload(32'd8);
				FB_ARRAY16:                st = begin_header(HK_ARRAY, 3'd2);
				FB_ARRAY32:                st = begin_header(HK_ARRAY, 3'd4);
				FB_MAP16:                  st = begin_header(HK_MAP, 3'd2);
				FB_MAP32:                  st = begin_header(HK_MAP, 3'd4);
				default:                   st = STAT_ERR;
				endcase
			end
			return st;
		endfunction

		function status_t header_step(logic [7:0] b);
			hacc = {hacc[23:0], b};
			if (hleft != 0)
				hleft--;
			if (hleft != 0)
				return STAT_BUSY;
			ph = PH_FORMAT;
			case (hk)
			HK_LEN:  return begin_payload(hacc);
			HK_MAP:  return open_ctr({hacc, 1'b0});
			default: return open_ctr({1'b0, hacc});
			endcase
		endfunction

		function status_t payload_step();
			if (pleft != 0)
				pleft--;
			if (pleft != 0)
				return STAT_BUSY;
			ph = PH_FORMAT;
			return close_value();
		endfunction

		// Called for every byte the block accepts
		function void take_byte(logic [7:0] b, logic fin);
			status_t st;
			logic [NEST_W-1:0] held;
			byte_verdict_t v;
			held = lvl[NEST_W-1:0];
			if (total != '1)
				total++;
			case (ph)
			PH_HEADER:  st = header_step(b);
			PH_PAYLOAD: st = payload_step();
			default:    st = decode_format(b);
			endcase
			// buffer ran out before the value closed
			if (st == STAT_BUSY && fin)
				st = STAT_ERR;
			v.st = st;
			v.used = total;
			v.nest = (st == STAT_ERR) ? held : lvl[NEST_W-1:0];
			verdicts.push_back(v);
			if (st != STAT_BUSY)
				restart();
		endfunction

		function void check_result(logic [1:0] st, logic [BYTES_W-1:0] used,
				logic [NEST_W-1:0] nest);
			byte_verdict_t v;
			if (verdicts.size() == 0) begin
				$display("%0t: result with no byte pending: status %0d bytes_used %0d nest_level %0d",
					$time, st, used, nest);
				errors++;
				return;
			end
			v = verdicts.pop_front();
			if (st !== v.st) begin
				$display("%0t: status expected %0d, got %0d", $time, v.st, st);
				errors++;
			end
			if (used !== v.used) begin
				$display("%0t: bytes_used expected %0d, got %0d", $time, v.used, used);
				errors++;
			end
			if (nest !== v.nest) begin
				$display("%0t: nest_level expected %0d, got %0d", $time, v.nest, nest);
				errors++;
			end
		endfunction

		function int pending();
			return verdicts.size();
		endfunction
	endclass

	logic               clk = 1'b0;
	logic               arst_n = 1'b0;
	logic               in_valid = 1'b0;
	logic               in_ready;
	logic [7:0]         data_byte = 8'h00;
	logic               final_byte = 1'b0;
	logic               out_valid;
	logic               out_ready = 1'b0;
	logic [1:0]         status;
	logic [BYTES_W-1:0] bytes_used;
	logic [NEST_W-1:0]  nest_level;

	msgpack_tracker tracker = new();

	// Idle percentages per cycle, changed between traffic phases
	int tx_idle_pct = 23;
	int rx_idle_pct = 82;
	int bytes_sent = 0;
	logic [7:0] msg_buf [$];

	msgpack_value_skipper_core dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.data_byte  (data_byte),
		.final_byte (final_byte),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.status     (status),
		.bytes_used (bytes_used),
		.nest_level (nest_level)
	);

	always #10 clk = ~clk;

	// Result side: check on handshake, then pick the next ready value
	initial begin
		forever begin
			@(posedge clk);
			if (arst_n && out_valid && out_ready)
				tracker.check_result(status, bytes_used, nest_level);
			out_ready <= ($urandom_range(0, 99) >= rx_idle_pct);
		end
	end

	initial begin
		#10_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	task automatic send_byte(input logic [7:0] b, input logic fin);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		data_byte <= b;
		final_byte <= fin;
		do @(posedge clk); while (!in_ready);
		tracker.take_byte(b, fin);
		bytes_sent++;
	endtask

	// Sends msg_buf[0..last]; only the last byte may carry the end-of-buffer mark
	task automatic send_buf(input int last, input logic fin);
		for (int i = 0; i <= last; i++)
			send_byte(msg_buf[i], (i == last) && fin);
	endtask

	function automatic void push_be(input logic [31:0] v, input int nb);
		for (int i = nb - 1; i >= 0; i--)
			msg_buf.push_back(v[8*i +: 8]);
	endfunction

	// Appends one well-formed value; open containers are tracked by their owed child counts
	function automatic void gen_value();
		int owed [$];
		int depth, pick, n, hb, kids;
		logic [7:0] code;
		owed.push_back(1);
		while (owed.size() != 0) begin
			if (owed[owed.size()-1] == 0) begin
				void'(owed.pop_back());
				continue;
			end
			owed[owed.size()-1]--;
			depth = owed.size() - 1;
			pick = (depth < 4) ? $urandom_range(0, 11) : $urandom_range(0, 5);
			kids = 0;
			n = 0;
			hb = 0;
			code = FB_NIL;
			case (pick)
			0: msg_buf.push_back(8'($urandom_range(0, FB_POSFIX_MAX)));
			1: msg_buf.push_back(8'($urandom_range(FB_NEGFIX_MIN, 8'hff)));
			2: begin
				case ($urandom_range(0, 2))
				0: code = FB_NIL;
				1: code = FB_FALSE;
				default: code = FB_TRUE;
				endcase
				msg_buf.push_back(code);
			end
			3: begin
				case ($urandom_range(0, 9))
				0: begin code = FB_UINT8;   n = 1; end
				1: begin code = FB_INT8;    n = 1; end
				2: begin code = FB_UINT16;  n = 2; end
				3: begin code = FB_INT16;   n = 2; end
				4: begin code = FB_UINT32;  n = 4; end
				5: begin code = FB_INT32;   n = 4; end
				6: begin code = FB_FLOAT32; n = 4; end
				7: begin code = FB_UINT64;  n = 8; end
				8: begin code = FB_INT64;   n = 8; end
				default: begin code = FB_FLOAT64; n = 8; end
				endcase
				msg_buf.push_back(code);
				repeat (n) msg_buf.push_back(8'($urandom));
			end
			4: begin
				n = ($urandom_range(0, 9) == 0) ? 31 : $urandom_range(0, 5);
				msg_buf.push_back(FB_FIXSTR | 8'(n));
				repeat (n) msg_buf.push_back(8'($urandom));
			end
			5: begin
				case ($urandom_range(0, 5))
				0: begin code = FB_BIN8;  hb = 1; end
				1: begin code = FB_STR8;  hb = 1; end
				2: begin code = FB_BIN16; hb = 2; end
				3: begin code = FB_STR16; hb = 2; end
				4: begin code = FB_BIN32; hb = 4; end
				default: begin code = FB_STR32; hb = 4; end
				endcase
				n = $urandom_range(0, 6);
				msg_buf.push_back(code);
				push_be(32'(n), hb);
				repeat (n) msg_buf.push_back(8'($urandom));
			end
			6, 7: begin
				// widest fixarray now and then, filled with scalars only
				n = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, (depth < 2) ? 3 : 1);
				msg_buf.push_back(FB_FIXARRAY | 8'(n));
				kids = n;
			end
			8: begin
				n = ($urandom_range(0, 19) == 0) ? 15 : $urandom_range(0, (depth < 2) ? 2 : 1);
				msg_buf.push_back(FB_FIXMAP | 8'(n));
				kids = 2 * n;
			end
			default: begin
				case ($urandom_range(0, 3))
				0: begin code = FB_ARRAY16; hb = 2; end
				1: begin code = FB_ARRAY32; hb = 4; end
				2: begin code = FB_MAP16;   hb = 2; end
				default: begin code = FB_MAP32; hb = 4; end
				endcase
				n = $urandom_range(0, 2);
				msg_buf.push_back(code);
				push_be(32'(n), hb);
				kids = (code == FB_MAP16 || code == FB_MAP32) ? 2 * n : n;
			end
			endcase
			if (kids > 0) begin
				// a 15-wide container keeps its children at scalar depth
				if (kids > 6) begin
					while (owed.size() < 5)
						owed.push_back(0);
				end
				owed.push_back(kids);
			end
		end
	endfunction

	task automatic run_traffic(input int upto);
		int pick, n, cut, hb;
		logic [7:0] code;
		logic [7:0] b;
		while (bytes_sent < upto) begin
			msg_buf.delete();
			pick = $urandom_range(0, 99);
			if (pick < 65) begin
				// well-formed value, sometimes cut short by the end of the buffer
				gen_value();
				if ($urandom_range(0, 6) == 0) begin
					cut = $urandom_range(0, msg_buf.size() - 1);
					send_buf(cut, 1'b1);
				end else begin
					send_buf(msg_buf.size() - 1, $urandom_range(0, 3) == 0);
				end
			end else if (pick < 75) begin
				// nesting right around the stack limit
				n = $urandom_range(29, 34);
				repeat (n) msg_buf.push_back(FB_FIXARRAY | 8'd1);
				msg_buf.push_back(8'($urandom_range(0, FB_POSFIX_MAX)));
				send_buf(msg_buf.size() - 1, $urandom_range(0, 1));
			end else if (pick < 82) begin
				// huge length or count that the buffer end interrupts
				case ($urandom_range(0, 7))
				0: begin code = FB_ARRAY16; hb = 2; end
				1: begin code = FB_ARRAY32; hb = 4; end
				2: begin code = FB_MAP16;   hb = 2; end
				3: begin code = FB_MAP32;   hb = 4; end
				4: begin code = FB_BIN16;   hb = 2; end
				5: begin code = FB_BIN32;   hb = 4; end
				6: begin code = FB_STR16;   hb = 2; end
				default: begin code = FB_STR32; hb = 4; end
				endcase
				msg_buf.push_back(code);
				push_be($urandom | 32'h8000_8000, hb);
				repeat ($urandom_range(0, 3))
					msg_buf.push_back(8'($urandom_range(0, FB_POSFIX_MAX)));
				send_buf(msg_buf.size() - 1, 1'b1);
			end else begin
				// noise, with a good share of rejected format codes
				repeat ($urandom_range(1, 4)) begin
					case ($urandom_range(0, 5))
					0: b = FB_RESERVED;
					1: b = 8'($urandom_range(FB_EXT8, FB_EXT32));
					2: b = 8'($urandom_range(FB_FIXEXT1, FB_FIXEXT16));
					default: b = 8'($urandom);
					endcase
					send_byte(b, $urandom_range(0, 7) == 0);
				end
			end
		end
	endtask

	initial begin
		repeat (4) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed: byte extremes, rejected codes, empty containers, widest counts
		msg_buf.delete();
		msg_buf.push_back(8'h00);
		msg_buf.push_back(FB_POSFIX_MAX);
		msg_buf.push_back(FB_NEGFIX_MIN);
		msg_buf.push_back(8'hff);
		send_buf(3, 1'b1);

		msg_buf.delete();
		msg_buf.push_back(FB_RESERVED);
		msg_buf.push_back(FB_FIXEXT16);
		msg_buf.push_back(FB_FIXARRAY);
		msg_buf.push_back(FB_FIXMAP);
		msg_buf.push_back(FB_FIXSTR);
		send_buf(4, 1'b0);

		// largest array count, buffer ends with the array still open
		msg_buf.delete();
		msg_buf.push_back(FB_ARRAY32);
		push_be(32'hffff_ffff, 4);
		msg_buf.push_back(FB_NIL);
		send_buf(5, 1'b1);

		// largest map count needs the 33rd counter bit
		msg_buf.delete();
		msg_buf.push_back(FB_MAP32);
		push_be(32'hffff_ffff, 4);
		msg_buf.push_back(FB_TRUE);
		send_buf(5, 1'b1);

		// zero-length str32 completes on its last header byte
		msg_buf.delete();
		msg_buf.push_back(FB_STR32);
		push_be(32'h0, 4);
		msg_buf.push_back(FB_FIXARRAY | 8'd2);
		msg_buf.push_back(FB_FALSE);
		msg_buf.push_back(FB_UINT8);
		msg_buf.push_back(8'h80);
		send_buf(8, 1'b1);

		run_traffic(370);
		tx_idle_pct = 82;
		rx_idle_pct = 23;
		run_traffic(700);
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		run_traffic(1030);
		in_valid <= 1'b0;

		while (tracker.pending() != 0)
			@(posedge clk);
		repeat (TAIL_CYCLES) @(posedge clk);

		if (tracker.errors == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end

endmodule
